// ===== design/bfie_pkg.sv =====
// shared types, codes and defaults of the instruction engine
package bfie_pkg;

	// default store sizes
	localparam int unsigned PROG_DEPTH_DEF = 4096;
	localparam int unsigned TAPE_DEPTH_DEF = 2048;

	// command codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EXEC = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_HALTED    = 2'd1;
	localparam logic [1:0] ST_UNMATCHED = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// instruction characters
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// command transaction payload
	typedef struct packed {
		logic       op;
		logic [7:0] code_byte;
	} cmd_t;

	// response transaction payload
	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic [1:0] status;
	} rsp_t;

	// scan direction
	typedef enum logic {
		SCAN_FWD = 1'b0,
		SCAN_BWD = 1'b1
	} scan_dir_t;

	// flags from the bracket scan unit
	typedef struct packed {
		logic match;
		logic zero;
	} scan_flags_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SCAN_F,
		S_SCAN_B,
		S_RESP
	} state_t;

endpackage

// ===== design/bfie_ram.sv =====
// generic single write port ram with registered read
module bfie_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/bfie_scan.sv =====
// bracket scan unit: one program byte per step, forward or backward
module bfie_scan
	import bfie_pkg::*;
#(
	parameter int unsigned DW = 13
) (
	input  logic [7:0]    code,
	input  scan_dir_t     dir,
	input  logic [DW-1:0] depth,
	output logic [DW-1:0] depth_nxt,
	output scan_flags_t   flags
);

	logic opens;
	logic closes;

	// a bracket that nests deeper in the scan direction, or one that closes a level
	assign opens  = (dir == SCAN_FWD) ? (code == CH_OPEN)  : (code == CH_CLOSE);
	assign closes = (dir == SCAN_FWD) ? (code == CH_CLOSE) : (code == CH_OPEN);

	always_comb begin
		depth_nxt = depth;
		if (opens) begin
			depth_nxt = depth + 1'b1;
		end else if (closes) begin
			depth_nxt = depth - 1'b1;
		end
	end

	assign flags.match = closes && (depth == DW'(1));
	assign flags.zero  = (code == CH_NUL);

endmodule

// ===== design/bf_instruction_engine_core.sv =====
// instruction engine top level: sequencer, program store, tape and response register
//
// The engine takes one command transaction at a time. A load finishes in the cycle in
// which it is taken. An execute first reads the program store at the program counter
// and the tape at the data pointer, then decodes and writes back in S_EXEC. A taken
// bracket then walks the program in S_SCAN_F or S_SCAN_B (the single bracket scan unit
// steps one byte per cycle over the program store read port). Halted executes and
// executes past the end of the program finish in S_IDLE without entering S_EXEC. When a
// transaction finishes while the previous response is still held by rsp_stall, the new
// response waits in a holding register and the next command is taken in the cycle
// after the one in which the stall drops. After reset all TAPE_DEPTH tape cells (2048 at
// the default size) are zeroed one cell per cycle, with cmd_stall high.
module bf_instruction_engine_core
	import bfie_pkg::*;
#(
	parameter int unsigned PROG_DEPTH = PROG_DEPTH_DEF,
	parameter int unsigned TAPE_DEPTH = TAPE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned PAW = $clog2(PROG_DEPTH);
	localparam int unsigned PLW = $clog2(PROG_DEPTH + 1);
	localparam int unsigned TAW = $clog2(TAPE_DEPTH);

	state_t state_q, state_d;

	logic [PLW-1:0] len_q, len_d;
	logic [PLW-1:0] pc_q, pc_d;
	logic [PLW-1:0] k_q, k_d;
	logic [PLW-1:0] depth_q, depth_d;
	logic [TAW-1:0] dp_q, dp_d;
	logic [TAW-1:0] clr_q;
	logic           halted_q, halt_set;

	rsp_t res_q, fin_res, out_d;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic accept, out_free, out_load, fin, go_exec, go_fwd, go_bwd, clr_last;
	logic [PLW-1:0] pc_inc, k_inc;

	logic           prog_we;
	logic [PAW-1:0] prog_raddr;
	logic [7:0]     prog_rdata;
	logic           tape_we;
	logic [TAW-1:0] tape_waddr;
	logic [7:0]     tape_wdata;
	logic [7:0]     tape_rdata;

	logic [PLW-1:0] scan_depth;
	scan_flags_t    scan_flags;
	scan_dir_t      scan_dir;

	// handshake helpers
	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign pc_inc    = pc_q + 1'b1;
	assign k_inc     = k_q + 1'b1;
	assign clr_last  = (clr_q == TAW'(TAPE_DEPTH - 1));
	assign scan_dir  = (state_q == S_SCAN_B) ? SCAN_BWD : SCAN_FWD;

	// program store
	bfie_ram #(
		.WIDTH (8),
		.DEPTH (PROG_DEPTH)
	) u_prog (
		.clk   (clk),
		.we    (prog_we),
		.waddr (len_q[PAW-1:0]),
		.wdata (cmd.code_byte),
		.raddr (prog_raddr),
		.rdata (prog_rdata)
	);

	// tape
	bfie_ram #(
		.WIDTH (8),
		.DEPTH (TAPE_DEPTH)
	) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (dp_q),
		.rdata (tape_rdata)
	);

	// shared bracket scan step
	bfie_scan #(
		.DW (PLW)
	) u_scan (
		.code      (prog_rdata),
		.dir       (scan_dir),
		.depth     (depth_q),
		.depth_nxt (scan_depth),
		.flags     (scan_flags)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE, S_EXEC, S_SCAN_F, S_SCAN_B: begin
				if (fin) begin
					state_d = out_free ? S_IDLE : S_RESP;
				end else if (go_exec) begin
					state_d = S_EXEC;
				end else if (go_fwd) begin
					state_d = S_SCAN_F;
				end else if (go_bwd) begin
					state_d = S_SCAN_B;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// sequencer outputs and register updates
	always_comb begin
		fin        = 1'b0;
		fin_res    = '{out_valid: 1'b0, out_byte: 8'h00, status: ST_OK};
		go_exec    = 1'b0;
		go_fwd     = 1'b0;
		go_bwd     = 1'b0;
		halt_set   = 1'b0;
		prog_we    = 1'b0;
		prog_raddr = pc_q[PAW-1:0];
		tape_we    = 1'b0;
		tape_waddr = dp_q;
		tape_wdata = 8'h00;
		len_d      = len_q;
		pc_d       = pc_q;
		dp_d       = dp_q;
		k_d        = k_q;
		depth_d    = depth_q;
		unique case (state_q)
			S_CLEAR: begin
				tape_we    = 1'b1;
				tape_waddr = clr_q;
			end
			S_IDLE: begin
				if (accept) begin
					if (cmd.op == OP_LOAD) begin
						fin = 1'b1;
						if (len_q == PLW'(PROG_DEPTH)) begin
							fin_res.status = ST_FULL;
						end else begin
							prog_we = 1'b1;
							len_d   = len_q + 1'b1;
						end
					end else if (halted_q) begin
						fin            = 1'b1;
						fin_res.status = ST_HALTED;
					end else if (pc_q >= len_q) begin
						fin            = 1'b1;
						fin_res.status = ST_HALTED;
						halt_set       = 1'b1;
					end else begin
						go_exec = 1'b1;
					end
				end
			end
			S_EXEC: begin
				if (prog_rdata == CH_NUL) begin
					fin            = 1'b1;
					fin_res.status = ST_HALTED;
					halt_set       = 1'b1;
				end else begin
					unique case (prog_rdata)
						CH_RIGHT: begin
							fin  = 1'b1;
							pc_d = pc_inc;
							dp_d = (dp_q == TAW'(TAPE_DEPTH - 1)) ? '0 : dp_q + 1'b1;
						end
						CH_LEFT: begin
							fin  = 1'b1;
							pc_d = pc_inc;
							dp_d = (dp_q == '0) ? TAW'(TAPE_DEPTH - 1) : dp_q - 1'b1;
						end
						CH_INC: begin
							fin        = 1'b1;
							pc_d       = pc_inc;
							tape_we    = 1'b1;
							tape_wdata = tape_rdata + 8'd1;
						end
						CH_DEC: begin
							fin        = 1'b1;
							pc_d       = pc_inc;
							tape_we    = 1'b1;
							tape_wdata = tape_rdata - 8'd1;
						end
						CH_OUT: begin
							fin               = 1'b1;
							pc_d              = pc_inc;
							fin_res.out_valid = 1'b1;
							fin_res.out_byte  = tape_rdata;
						end
						CH_OPEN: begin
							if (tape_rdata != 8'h00) begin
								fin  = 1'b1;
								pc_d = pc_inc;
							end else if (pc_inc >= len_q) begin
								fin            = 1'b1;
								fin_res.status = ST_UNMATCHED;
								halt_set       = 1'b1;
							end else begin
								go_fwd     = 1'b1;
								k_d        = pc_inc;
								depth_d    = PLW'(1);
								prog_raddr = pc_inc[PAW-1:0];
							end
						end
						CH_CLOSE: begin
							if (tape_rdata == 8'h00) begin
								fin  = 1'b1;
								pc_d = pc_inc;
							end else if (pc_q == '0) begin
								fin            = 1'b1;
								fin_res.status = ST_UNMATCHED;
								halt_set       = 1'b1;
							end else begin
								go_bwd     = 1'b1;
								k_d        = pc_q - 1'b1;
								depth_d    = PLW'(1);
								prog_raddr = k_d[PAW-1:0];
							end
						end
						default: begin
							fin  = 1'b1;
							pc_d = pc_inc;
						end
					endcase
				end
			end
			S_SCAN_F: begin
				// a zero byte or the end of the program ends the forward scan unmatched
				if (scan_flags.zero) begin
					fin            = 1'b1;
					fin_res.status = ST_UNMATCHED;
					halt_set       = 1'b1;
				end else if (scan_flags.match) begin
					fin  = 1'b1;
					pc_d = k_inc;
				end else if (k_inc >= len_q) begin
					fin            = 1'b1;
					fin_res.status = ST_UNMATCHED;
					halt_set       = 1'b1;
				end else begin
					k_d        = k_inc;
					depth_d    = scan_depth;
					prog_raddr = k_inc[PAW-1:0];
				end
			end
			S_SCAN_B: begin
				// the backward scan fails only when it passes the start of the program
				if (scan_flags.match) begin
					fin  = 1'b1;
					pc_d = k_inc;
				end else if (k_q == '0) begin
					fin            = 1'b1;
					fin_res.status = ST_UNMATCHED;
					halt_set       = 1'b1;
				end else begin
					k_d        = k_q - 1'b1;
					depth_d    = scan_depth;
					prog_raddr = k_d[PAW-1:0];
				end
			end
			S_RESP: begin
				prog_raddr = pc_q[PAW-1:0];
			end
			default: begin
				prog_raddr = pc_q[PAW-1:0];
			end
		endcase
	end

	// response register feed
	assign out_load = out_free && (fin || (state_q == S_RESP));
	assign out_d    = (state_q == S_RESP) ? res_q : fin_res;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			len_q       <= '0;
			pc_q        <= '0;
			dp_q        <= '0;
			halted_q    <= 1'b0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			pc_q    <= pc_d;
			dp_q    <= dp_d;
			if (halt_set) begin
				halted_q <= 1'b1;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		k_q     <= k_d;
		depth_q <= depth_d;
		if (fin) begin
			res_q <= fin_res;
		end
		if (out_load) begin
			rsp_q <= out_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/bfie_checker.sv =====
// port level checks of the instruction engine, bound to the top level
module bfie_checker
	import bfie_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a held response transaction stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// an emitted byte always comes with ok status
	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_valid |-> rsp.status == ST_OK)
		else $error("emitted byte with non-ok status");

	// no emission means a zero byte field
	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.out_valid |-> rsp.out_byte == 8'h00)
		else $error("byte field set without emission");

	// a load answers in the next cycle when the response register is free
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && (cmd.op == OP_LOAD) && (!rsp_valid || !rsp_stall)
		|=> rsp_valid && !rsp.out_valid && (rsp.status == ST_OK || rsp.status == ST_FULL))
		else $error("load response missing or wrong");

endmodule

bind bf_instruction_engine_core bfie_checker u_bfie_checker (.*);
